/* design/atp_pkg.sv */
// Shared types, constants and helper functions for the tilt and proximity pipeline.
package atp_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;

  // datapath widths
  localparam int XW     = 36;  // CORDIC x/y, operands scaled by 2^16 plus gain headroom
  localparam int ZW     = 27;  // angle accumulator, 2^-16 degree units
  localparam int ROOT_W = 32;  // integer root of (y^2+z^2)*2^32
  localparam int REM_W  = 34;
  localparam int RAD_W  = 32;

  localparam int QUARTER_TURN = 5898240;  // 90 degrees in 2^-16 degree units

  localparam logic signed [15:0] ROLL_LIMIT  = 16'sd23040;
  localparam logic signed [15:0] PITCH_LIMIT = 16'sd11520;

  typedef logic signed [XW-1:0] xy_t;
  typedef logic signed [ZW-1:0] ang_t;

  typedef struct packed {
    xy_t  x;
    xy_t  y;
    ang_t z;
    logic zero;   // both operands were zero
    logic flag;   // passenger bit riding along
  } cordic_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
    logic signed [15:0] ax;
  } sqrt_t;

  // atan(2^-i) in 2^-16 degree units, rounded to nearest
  function automatic ang_t atan_q16(input logic [4:0] idx);
    ang_t a;
    unique case (idx)
      5'd0:  a = ang_t'(2949120);
      5'd1:  a = ang_t'(1740967);
      5'd2:  a = ang_t'(919879);
      5'd3:  a = ang_t'(466945);
      5'd4:  a = ang_t'(234379);
      5'd5:  a = ang_t'(117304);
      5'd6:  a = ang_t'(58666);
      5'd7:  a = ang_t'(29335);
      5'd8:  a = ang_t'(14668);
      5'd9:  a = ang_t'(7334);
      5'd10: a = ang_t'(3667);
      5'd11: a = ang_t'(1833);
      5'd12: a = ang_t'(917);
      5'd13: a = ang_t'(458);
      5'd14: a = ang_t'(229);
      5'd15: a = ang_t'(115);
      5'd16: a = ang_t'(57);
      5'd17: a = ang_t'(29);
      5'd18: a = ang_t'(14);
      5'd19: a = ang_t'(7);
      5'd20: a = ang_t'(4);
      5'd21: a = ang_t'(2);
      5'd22: a = ang_t'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

  // Vectoring start: turn a left-half-plane vector by +-90 deg into the right half.
  function automatic cordic_t cordic_init(input xy_t y, input xy_t x, input logic flag);
    cordic_t c;
    c.zero = (x == '0) && (y == '0);
    c.flag = flag;
    if (x < 0) begin
      if (y >= 0) begin
        c.x = y;
        c.y = -x;
        c.z = ang_t'(QUARTER_TURN);
      end else begin
        c.x = -y;
        c.y = x;
        c.z = -ang_t'(QUARTER_TURN);
      end
    end else begin
      c.x = x;
      c.y = y;
      c.z = '0;
    end
    return c;
  endfunction

  // 2^-16 deg -> 1/128 deg, ties away from zero, then clamp.
  function automatic logic signed [15:0] round_clamp(input ang_t z, input logic zero,
                                                      input logic signed [15:0] lim);
    logic [ZW-1:0]        mag;
    logic [ZW-1:0]        q;
    logic signed [ZW-1:0] r;
    mag = z[ZW-1] ? ZW'(-z) : ZW'(z);
    q   = (mag + ZW'(256)) >> 9;
    r   = z[ZW-1] ? -$signed(q) : $signed(q);
    if (zero) begin
      r = '0;
    end else if (r > ang_t'(lim)) begin
      r = ang_t'(lim);
    end else if (r < -ang_t'(lim)) begin
      r = -ang_t'(lim);
    end
    return r[15:0];
  endfunction

endpackage

/* design/atp_sqrt_cell.sv */
// One root bit of the pipelined integer square root.
module atp_sqrt_cell (
  input  logic            clk,
  input  logic            en,
  input  atp_pkg::sqrt_t  d_i,
  output atp_pkg::sqrt_t  q_o
);

  atp_pkg::sqrt_t               cell_r;
  atp_pkg::sqrt_t               cell_nxt;
  logic [atp_pkg::REM_W+1:0]    rem_sh;
  logic [atp_pkg::REM_W+1:0]    trial;

  always_comb begin
    rem_sh   = {d_i.rem, d_i.rad[atp_pkg::RAD_W-1 -: 2]};
    trial    = {2'b00, d_i.root, 2'b01};
    cell_nxt = d_i;
    cell_nxt.rad = {d_i.rad[atp_pkg::RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      cell_nxt.rem  = atp_pkg::REM_W'(rem_sh - trial);
      cell_nxt.root = {d_i.root[atp_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      cell_nxt.rem  = rem_sh[atp_pkg::REM_W-1:0];
      cell_nxt.root = {d_i.root[atp_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign q_o = cell_r;

endmodule

/* design/atp_cordic_cell.sv */
// One vectoring CORDIC micro-rotation with a fixed shift.
module atp_cordic_cell #(
  parameter int SHIFT = 0
) (
  input  logic              clk,
  input  logic              en,
  input  atp_pkg::cordic_t  d_i,
  output atp_pkg::cordic_t  q_o
);

  atp_pkg::cordic_t cell_r;
  atp_pkg::cordic_t cell_nxt;
  atp_pkg::xy_t     xs;
  atp_pkg::xy_t     ys;
  atp_pkg::ang_t    step;

  always_comb begin
    xs       = d_i.x >>> SHIFT;
    ys       = d_i.y >>> SHIFT;
    step     = atp_pkg::atan_q16(5'(SHIFT));
    cell_nxt = d_i;
    if (!d_i.y[atp_pkg::XW-1]) begin
      cell_nxt.x = d_i.x + ys;
      cell_nxt.y = d_i.y - xs;
      cell_nxt.z = d_i.z + step;
    end else begin
      cell_nxt.x = d_i.x - ys;
      cell_nxt.y = d_i.y + xs;
      cell_nxt.z = d_i.z - step;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign q_o = cell_r;

endmodule

/* design/accel_tilt_and_proximity.sv */
// Top level: roll, pitch and obstacle flag from one accelerometer/range sample per word.
//
// Takes one sample word per clock and returns one result word per sample, in order.
// Pipeline depth is set by the pitch path, which runs through these registers in order:
// an input register that also squares y and z, a sum stage, 32 square-root cells (one
// root bit each) and CORDIC_STEPS vectoring CORDIC cells, then the output register. Roll
// runs through its own CORDIC_STEPS cells straight after the input register and waits in
// a 33-deep delay line to line up with pitch. Throughput is one word per cycle; the whole
// pipe holds still only while a finished result sits in the output register and
// out_tready is low. Angles come in 1/128 degree; atan2(0,0) reads as 0. The obstacle
// bit compares against the threshold register at the moment the sample is accepted;
// change the threshold only while the pipe is empty. Threshold resets to 200 mm.
module accel_tilt_and_proximity #(
  parameter int CORDIC_STEPS = atp_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // sample stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // accel_x[15:0], accel_y[31:16], accel_z[47:32], range_mm[63:48]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // roll_deg[15:0], pitch_deg[30:16], obstacle[31]
  // obstacle threshold register
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int LAT = 2 + atp_pkg::ROOT_W + CORDIC_STEPS;  // stages ahead of output reg

  // ---- control ----
  logic           adv;
  logic           in_acc;
  logic [LAT-1:0] vld_r;
  logic           out_tvalid_r;
  logic [15:0]    thr_r;

  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 16'd200;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      vld_r        <= {vld_r[LAT-2:0], in_acc};
      out_tvalid_r <= vld_r[LAT-1];
    end
  end

  // ---- input stage: unpack, square, threshold compare ----
  logic signed [15:0] in_ax, in_ay, in_az;
  logic [15:0]        in_range;
  logic signed [31:0] sqy_full, sqz_full;

  assign in_ax    = in_tdata[15:0];
  assign in_ay    = in_tdata[31:16];
  assign in_az    = in_tdata[47:32];
  assign in_range = in_tdata[63:48];
  assign sqy_full = in_ay * in_ay;
  assign sqz_full = in_az * in_az;

  logic signed [15:0] ax_r, ay_r, az_r, ax2_r;
  logic [30:0]        sqy_r, sqz_r;
  logic               obst_r;
  logic [31:0]        sumsq_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r    <= in_ax;
      ay_r    <= in_ay;
      az_r    <= in_az;
      sqy_r   <= sqy_full[30:0];
      sqz_r   <= sqz_full[30:0];
      obst_r  <= (in_range != 16'd0) && (in_range <= thr_r);
      // sum stage
      sumsq_r <= 32'(sqy_r) + 32'(sqz_r);
      ax2_r   <= ax_r;
    end
  end

  // ---- square root chain: root = floor(sqrt(sumsq * 2^32)) ----
  atp_pkg::sqrt_t sq_d [atp_pkg::ROOT_W+1];

  always_comb begin
    sq_d[0].rem  = '0;
    sq_d[0].root = '0;
    sq_d[0].rad  = sumsq_r;
    sq_d[0].ax   = ax2_r;
  end

  for (genvar k = 0; k < atp_pkg::ROOT_W; k++) begin : g_sqrt
    atp_sqrt_cell u_cell (
      .clk (clk),
      .en  (adv),
      .d_i (sq_d[k]),
      .q_o (sq_d[k+1])
    );
  end

  // ---- pitch CORDIC: atan2(-ax, root) ----
  atp_pkg::cordic_t pc_d [CORDIC_STEPS+1];
  atp_pkg::xy_t     p_y0, p_x0;

  assign p_y0  = -(atp_pkg::xy_t'(sq_d[atp_pkg::ROOT_W].ax) <<< 16);
  assign p_x0  = atp_pkg::xy_t'({{(atp_pkg::XW-atp_pkg::ROOT_W){1'b0}},
                                 sq_d[atp_pkg::ROOT_W].root});
  assign pc_d[0] = atp_pkg::cordic_init(p_y0, p_x0, 1'b0);

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_pitch
    atp_cordic_cell #(.SHIFT(i)) u_cell (
      .clk (clk),
      .en  (adv),
      .d_i (pc_d[i]),
      .q_o (pc_d[i+1])
    );
  end

  // ---- roll CORDIC: atan2(ay, az), obstacle bit rides along ----
  atp_pkg::cordic_t rc_d [CORDIC_STEPS+1];

  assign rc_d[0] = atp_pkg::cordic_init(atp_pkg::xy_t'(ay_r) <<< 16,
                                        atp_pkg::xy_t'(az_r) <<< 16, obst_r);

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_roll
    atp_cordic_cell #(.SHIFT(i)) u_cell (
      .clk (clk),
      .en  (adv),
      .d_i (rc_d[i]),
      .q_o (rc_d[i+1])
    );
  end

  // round roll, then delay it to meet pitch; bit 16 carries the obstacle flag
  logic signed [15:0] roll_rnd;
  logic [16:0]        dly_r [atp_pkg::ROOT_W+1];

  assign roll_rnd = atp_pkg::round_clamp(rc_d[CORDIC_STEPS].z, rc_d[CORDIC_STEPS].zero,
                                         atp_pkg::ROLL_LIMIT);

  always_ff @(posedge clk) begin
    if (adv) begin
      dly_r[0] <= {rc_d[CORDIC_STEPS].flag, roll_rnd};
      for (int j = 1; j < atp_pkg::ROOT_W + 1; j++) begin
        dly_r[j] <= dly_r[j-1];
      end
    end
  end

  // ---- output register ----
  logic signed [15:0] pitch_rnd;
  logic [31:0]        out_tdata_r;
  logic [16:0]        roll_tap;

  assign pitch_rnd = atp_pkg::round_clamp(pc_d[CORDIC_STEPS].z, pc_d[CORDIC_STEPS].zero,
                                          atp_pkg::PITCH_LIMIT);
  assign roll_tap  = dly_r[atp_pkg::ROOT_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= {roll_tap[16], pitch_rnd[14:0], roll_tap[15:0]};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

/* design/atp_checker.sv */
// Port-level checks for the tilt and proximity block, bound to the top level.
module atp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // a result held back by the sink stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result word changed while stalled");

  // input side never blocks unless the output register is stuck
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled without output back-pressure");

  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (($signed(out_tdata[15:0]) <= 16'sd23040) &&
                    ($signed(out_tdata[15:0]) >= -16'sd23040)))
    else $error("roll out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (($signed(out_tdata[30:16]) <= 15'sd11520) &&
                    ($signed(out_tdata[30:16]) >= -15'sd11520)))
    else $error("pitch out of range");

endmodule

bind accel_tilt_and_proximity atp_checker u_atp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
